// ===== rtl/ptc_pkg.sv =====
package ptc_pkg;

  // config port geometry: six 32-bit registers at byte offsets 0..20
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  // start-to-result pipeline depth
  localparam int LATENCY = 12;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRESSURE_OFFSET        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SENSITIVITY_TEMP_COEFF = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REFERENCE_TEMPERATURE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TEMPERATURE_COEFF      = 3'd5;

  // 20.00 C band edge, and distance from it to the -15.00 C edge
  localparam logic signed [19:0] TEMP_REF      = 20'sd2000;
  localparam logic signed [19:0] TEMP_VLOW_OFS = 20'sd3500;

  // ceil(2^35 / 10): exact divide by ten for operands below 2^32
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [15:0] pressure_sensitivity;
    logic [15:0] pressure_offset;
    logic [15:0] sensitivity_temp_coeff;
    logic [15:0] offset_temp_coeff;
    logic [15:0] reference_temperature;
    logic [15:0] temperature_coeff;
  } cal_t;

endpackage

// ===== rtl/ptc_datapath.sv =====
module ptc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic [23:0]         in_raw_pressure,
  input  logic [23:0]         in_raw_temperature,
  input  ptc_pkg::cal_t       cal,
  output logic                out_valid,
  output logic signed [18:0]  out_temperature,
  output logic signed [31:0]  out_pressure
);

  localparam int NS = ptc_pkg::LATENCY;

  logic [NS-1:0] vld_r;

  // stage 1
  logic [23:0]        s1_rp_r;
  logic signed [24:0] s1_dt_r, s1_dt;
  // stage 2
  logic [23:0]        s2_rp_r;
  logic signed [41:0] s2_p3_r, s2_p4_r, s2_p6_r;
  logic signed [41:0] s2_p3, s2_p4, s2_p6;
  logic signed [49:0] s2_dsqf;
  logic [48:0]        s2_dsq_r;
  // stage 3
  logic [23:0]        s3_rp_r;
  logic signed [39:0] s3_sens1_r, s3_off1_r, s3_sens1, s3_off1;
  logic signed [18:0] s3_tdiff_r, s3_tdiff;
  logic signed [19:0] s3_e_r, s3_e, s3_temp1_r, s3_temp1;
  logic [16:0]        s3_ti_r, s3_ti;
  logic signed [41:0] s3_t3, s3_t4, s3_t6;
  logic [49:0]        s3_dsq3;
  // stage 4
  logic [23:0]        s4_rp_r;
  logic signed [39:0] s4_sens1_r, s4_off1_r;
  logic signed [19:0] s4_temp_r;
  logic signed [37:0] s4_d2f;
  logic signed [39:0] s4_e2f;
  logic [34:0]        s4_d2_r;
  logic [35:0]        s4_e2_r;
  logic               s4_low_r, s4_vlow_r;
  // stage 5
  logic [23:0]        s5_rp_r;
  logic signed [39:0] s5_sens1_r, s5_off1_r;
  logic signed [19:0] s5_temp_r;
  logic [39:0]        s5_offi_r, s5_sensi_r, s5_offi, s5_sensi;
  logic [35:0]        s5_d2x3;
  logic [36:0]        s5_d2x5;
  logic [38:0]        s5_e2x7;
  // stage 6
  logic [23:0]        s6_rp_r;
  logic signed [19:0] s6_temp_r;
  logic signed [40:0] s6_off, s6_sens;
  logic signed [39:0] s6_off_r, s6_sens_r;
  // stage 7
  logic signed [19:0] s7_temp_r;
  logic signed [39:0] s7_off_r;
  logic signed [44:0] s7_pp_lo_r, s7_pp_hi_r, s7_pp_lo, s7_pp_hi;
  // stage 8
  logic signed [19:0] s8_temp_r;
  logic signed [39:0] s8_off_r;
  logic signed [63:0] s8_prod_r, s8_prod;
  // stage 9
  logic signed [19:0] s9_temp_r;
  logic signed [63:0] s9_t;
  logic signed [42:0] s9_q21;
  logic signed [43:0] s9_a_r, s9_a;
  // stage 10
  logic signed [19:0] s10_temp_r;
  logic signed [43:0] s10_t;
  logic [30:0]        s10_b, s10_mag_r, s10_mag;
  logic               s10_neg_r;
  // stage 11
  logic signed [19:0] s11_temp_r;
  logic [62:0]        s11_qf;
  logic [27:0]        s11_q_r;
  logic               s11_neg_r;
  // stage 12
  logic signed [18:0] out_temp_r;
  logic signed [31:0] out_pres_r, s12_pres;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NS-2:0], in_accept};
    end
  end

  always_comb begin
    // stage 1: temperature difference against the reference
    s1_dt = $signed({1'b0, in_raw_temperature})
          - $signed({1'b0, cal.reference_temperature, 8'd0});

    // stage 2: coefficient products and dt squared
    s2_p3   = $signed({1'b0, cal.sensitivity_temp_coeff}) * s1_dt_r;
    s2_p4   = $signed({1'b0, cal.offset_temp_coeff}) * s1_dt_r;
    s2_p6   = $signed({1'b0, cal.temperature_coeff}) * s1_dt_r;
    s2_dsqf = s1_dt_r * s1_dt_r;

    // stage 3: first-order terms, truncating divides by 2^k
    s3_t3    = s2_p3_r + $signed({34'd0, {8{s2_p3_r[41]}}});
    s3_t4    = s2_p4_r + $signed({35'd0, {7{s2_p4_r[41]}}});
    s3_t6    = s2_p6_r + $signed({19'd0, {23{s2_p6_r[41]}}});
    s3_sens1 = $signed({9'd0, cal.pressure_sensitivity, 15'd0}) + 40'($signed(s3_t3[41:8]));
    s3_off1  = $signed({8'd0, cal.pressure_offset, 16'd0}) + 40'($signed(s3_t4[41:7]));
    s3_tdiff = s3_t6[41:23];
    s3_temp1 = ptc_pkg::TEMP_REF + 20'(s3_tdiff);
    s3_e     = ptc_pkg::TEMP_VLOW_OFS + 20'(s3_tdiff);
    s3_dsq3  = {s2_dsq_r, 1'b0} + {1'b0, s2_dsq_r};
    // below 20 C: 3*dt^2/2^33, else dt^2/2^36
    s3_ti    = s3_tdiff[18] ? s3_dsq3[49:33] : {4'd0, s2_dsq_r[48:36]};

    // stage 4: squares of the band distances
    s4_d2f = s3_tdiff_r * s3_tdiff_r;
    s4_e2f = s3_e_r * s3_e_r;

    // stage 5: second-order offset and sensitivity terms
    s5_d2x3 = {s4_d2_r, 1'b0} + {1'b0, s4_d2_r};
    s5_d2x5 = {s4_d2_r, 2'b0} + {2'b0, s4_d2_r};
    s5_e2x7 = {s4_e2_r, 3'b0} - {3'b0, s4_e2_r};
    if (s4_low_r) begin
      s5_offi  = {5'd0, s5_d2x3[35:1]} + (s4_vlow_r ? {1'b0, s5_e2x7} : 40'd0);
      s5_sensi = {6'd0, s5_d2x5[36:3]} + (s4_vlow_r ? {s4_e2_r, 2'b0, 2'b0} >> 2 : 40'd0);
    end else begin
      s5_offi  = {9'd0, s4_d2_r[34:4]};
      s5_sensi = 40'd0;
    end

    // stage 6: corrected offset and sensitivity
    s6_off  = 41'(s5_off1_r) - $signed({1'b0, s5_offi_r});
    s6_sens = 41'(s5_sens1_r) - $signed({1'b0, s5_sensi_r});

    // stage 7: raw pressure times sensitivity, two 20-bit halves
    s7_pp_lo = $signed({1'b0, s6_rp_r}) * $signed({1'b0, s6_sens_r[19:0]});
    s7_pp_hi = $signed({1'b0, s6_rp_r}) * $signed(s6_sens_r[39:20]);

    // stage 8: recombine halves
    s8_prod = (64'(s7_pp_hi_r) <<< 20) + 64'(s7_pp_lo_r);

    // stage 9: /2^21 toward zero, minus offset
    s9_t   = s8_prod_r + $signed({43'd0, {21{s8_prod_r[63]}}});
    s9_q21 = s9_t[63:21];
    s9_a   = 44'(s9_q21) - 44'(s8_off_r);

    // stage 10: /2^13 toward zero, split sign and magnitude
    s10_t   = s9_a_r + $signed({31'd0, {13{s9_a_r[43]}}});
    s10_b   = s10_t[43:13];
    s10_mag = s10_b[30] ? (~s10_b + 31'd1) : s10_b;

    // stage 11: magnitude / 10 by reciprocal
    s11_qf = 63'(s10_mag_r) * 63'(ptc_pkg::RECIP10);

    // stage 12: restore sign
    s12_pres = s11_neg_r ? (~{4'd0, s11_q_r} + 32'd1) : {4'd0, s11_q_r};
  end

  always_ff @(posedge clk) begin
    s1_rp_r    <= in_raw_pressure;
    s1_dt_r    <= s1_dt;

    s2_rp_r    <= s1_rp_r;
    s2_p3_r    <= s2_p3;
    s2_p4_r    <= s2_p4;
    s2_p6_r    <= s2_p6;
    s2_dsq_r   <= s2_dsqf[48:0];

    s3_rp_r    <= s2_rp_r;
    s3_sens1_r <= s3_sens1;
    s3_off1_r  <= s3_off1;
    s3_tdiff_r <= s3_tdiff;
    s3_e_r     <= s3_e;
    s3_temp1_r <= s3_temp1;
    s3_ti_r    <= s3_ti;

    s4_rp_r    <= s3_rp_r;
    s4_sens1_r <= s3_sens1_r;
    s4_off1_r  <= s3_off1_r;
    s4_temp_r  <= s3_temp1_r - $signed({3'd0, s3_ti_r});
    s4_d2_r    <= s4_d2f[34:0];
    s4_e2_r    <= s4_e2f[35:0];
    s4_low_r   <= s3_tdiff_r[18];
    s4_vlow_r  <= s3_e_r[19];

    s5_rp_r    <= s4_rp_r;
    s5_sens1_r <= s4_sens1_r;
    s5_off1_r  <= s4_off1_r;
    s5_temp_r  <= s4_temp_r;
    s5_offi_r  <= s5_offi;
    s5_sensi_r <= s5_sensi;

    s6_rp_r    <= s5_rp_r;
    s6_temp_r  <= s5_temp_r;
    s6_off_r   <= s6_off[39:0];
    s6_sens_r  <= s6_sens[39:0];

    s7_temp_r  <= s6_temp_r;
    s7_off_r   <= s6_off_r;
    s7_pp_lo_r <= s7_pp_lo;
    s7_pp_hi_r <= s7_pp_hi;

    s8_temp_r  <= s7_temp_r;
    s8_off_r   <= s7_off_r;
    s8_prod_r  <= s8_prod;

    s9_temp_r  <= s8_temp_r;
    s9_a_r     <= s9_a;

    s10_temp_r <= s9_temp_r;
    s10_mag_r  <= s10_mag;
    s10_neg_r  <= s10_b[30];

    s11_temp_r <= s10_temp_r;
    s11_q_r    <= s11_qf[62:35];
    s11_neg_r  <= s10_neg_r;

    out_temp_r <= s11_temp_r[18:0];
    out_pres_r <= s12_pres;
  end

  assign out_valid       = vld_r[NS-1];
  assign out_temperature = out_temp_r;
  assign out_pressure    = out_pres_r;

endmodule

// ===== rtl/pressure_temperature_compensation.sv =====
// Pressure sensor second-order temperature compensation.
//
// Input channel: drive in_raw_pressure / in_raw_temperature (raw 24-bit
// conversions) with start high; the transaction is taken at the clock edge
// where start is high and busy is low. busy is only high right after reset,
// so in normal operation one transaction can be started every cycle.
// Result channel: out_valid strobes for exactly one cycle with
// out_temperature (0.01 C, signed) and out_pressure (mbar, signed).
// Each result passes through the registered pipeline below; results come out
// in start order at one per cycle. The receiver cannot stall the block: each
// result is on the ports for its strobe cycle only.
// Calibration words sit in six APB registers (byte offsets 0,4,..,20, low 16
// bits used); write them only while no transaction is in flight.
// Reset (synchronous, rst_n low) clears the calibration words and drops all
// transactions in flight; busy is high for the cycle after reset.
// Latency is set by a 12-stage pipeline of multipliers and adders; throughput
// is one transaction per cycle. The final pressure /10 uses a reciprocal multiply.
module pressure_temperature_compensation (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        start,
  output logic                        busy,
  input  logic [23:0]                 in_raw_pressure,
  input  logic [23:0]                 in_raw_temperature,
  // result channel
  output logic                        out_valid,
  output logic signed [18:0]          out_temperature,
  output logic signed [31:0]          out_pressure,
  // calibration register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  ptc_pkg::cal_t                   cal_r;
  logic                            busy_r;
  logic                            cfg_wr;
  logic                            in_accept;
  logic [ptc_pkg::REG_IDX_W-1:0]   cfg_idx;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[ptc_pkg::ADDR_W-1:2];
  assign in_accept = start && !busy_r;
  assign busy      = busy_r;

  // busy held for one cycle coming out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // calibration registers; writes past the last register are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ptc_pkg::REG_PRESSURE_SENSITIVITY:   cal_r.pressure_sensitivity   <= pwdata[15:0];
        ptc_pkg::REG_PRESSURE_OFFSET:        cal_r.pressure_offset        <= pwdata[15:0];
        ptc_pkg::REG_SENSITIVITY_TEMP_COEFF: cal_r.sensitivity_temp_coeff <= pwdata[15:0];
        ptc_pkg::REG_OFFSET_TEMP_COEFF:      cal_r.offset_temp_coeff      <= pwdata[15:0];
        ptc_pkg::REG_REFERENCE_TEMPERATURE:  cal_r.reference_temperature  <= pwdata[15:0];
        ptc_pkg::REG_TEMPERATURE_COEFF:      cal_r.temperature_coeff      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (cfg_idx)
      ptc_pkg::REG_PRESSURE_SENSITIVITY:   prdata = {16'd0, cal_r.pressure_sensitivity};
      ptc_pkg::REG_PRESSURE_OFFSET:        prdata = {16'd0, cal_r.pressure_offset};
      ptc_pkg::REG_SENSITIVITY_TEMP_COEFF: prdata = {16'd0, cal_r.sensitivity_temp_coeff};
      ptc_pkg::REG_OFFSET_TEMP_COEFF:      prdata = {16'd0, cal_r.offset_temp_coeff};
      ptc_pkg::REG_REFERENCE_TEMPERATURE:  prdata = {16'd0, cal_r.reference_temperature};
      ptc_pkg::REG_TEMPERATURE_COEFF:      prdata = {16'd0, cal_r.temperature_coeff};
      default:                             prdata = 32'd0;
    endcase
  end

  ptc_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_accept          (in_accept),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .cal                (cal_r),
    .out_valid          (out_valid),
    .out_temperature    (out_temperature),
    .out_pressure       (out_pressure)
  );

endmodule

// ===== rtl/ptc_checker.sv =====
module ptc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [ptc_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                pwdata,
  input logic [31:0]                prdata
);

  localparam int LAT = ptc_pkg::LATENCY;

  // reset flushes the pipeline and holds off new transactions
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid && busy)
    else $error("pipeline not flushed by reset");

  // every accepted transaction gives a strobe after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after start");

  // no strobe without a matching start
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without start");

  // out of reset, the block takes a transaction every cycle
  a_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy outside reset");

  // a write to a mapped register reads back on a read of the same address that directly follows it
  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(psel && penable && pwrite) && psel && !pwrite
     && paddr == $past(paddr)
     && $past(paddr[ptc_pkg::ADDR_W-1:2]) <= ptc_pkg::REG_TEMPERATURE_COEFF)
    |-> prdata == {16'd0, $past(pwdata[15:0])})
    else $error("register readback mismatch");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

// ===== tb/sv/testbench.sv =====
module testbench;

  // Indexes past the last calibration word. Writes there must leave every word alone.
  localparam logic [ptc_pkg::REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [ptc_pkg::REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam int CONVERSIONS_PER_SET = 150;
  localparam int SETTLE_CYCLES       = ptc_pkg::LATENCY + 4;
  localparam int WATCHDOG_LIMIT      = 4000;
  localparam int MAX_PRINTED         = 32;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } conversion_t;

  typedef struct packed {
    logic signed [18:0] temperature;
    logic signed [31:0] pressure;
  } reading_t;

  typedef enum logic [1:0] {BAND_HIGH, BAND_LOW, BAND_VERY_LOW} band_e;

  // Clock, and the reset that is held for the first cycles.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Input channel.
  logic        start              = 1'b0;
  logic        busy;
  logic [23:0] in_raw_pressure    = '0;
  logic [23:0] in_raw_temperature = '0;

  // Result channel.
  logic               out_valid;
  logic signed [18:0] out_temperature;
  logic signed [31:0] out_pressure;

  // Calibration register port.
  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [ptc_pkg::ADDR_W-1:0] paddr   = '0;
  logic [31:0]                pwdata  = '0;
  logic [31:0]                prdata;
  logic                       pready;

  pressure_temperature_compensation uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .out_valid          (out_valid),
    .out_temperature    (out_temperature),
    .out_pressure       (out_pressure),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial forever #4 clk = ~clk;

  // This copy of the calibration words follows every write that the block takes.
  ptc_pkg::cal_t cal_shadow = '0;
  conversion_t   pending_conversions[$];
  reading_t      expected_readings[$];

  int mismatches        = 0;
  int conversions_taken = 0;
  int results_checked   = 0;
  int cal_sets          = 1;
  int band_hits[3]      = '{0, 0, 0};
  int gap_left          = 0;
  logic back_to_back    = 1'b0;
  int idle_cycles       = 0;

  // Expected output of the block for one conversion pair. All math is done in
  // signed 64 bits. Every division truncates toward zero, as SV does for signed operands.
  function automatic void compensate(input logic [23:0] raw_p, input logic [23:0] raw_t,
                                     input ptc_pkg::cal_t c, output reading_t r,
                                     output band_e band);
    longint p_raw, t_raw, c1, c2, c3, c4, c5, c6;
    longint dt, sens, off, temp, t2, off2, sens2, x, y, pres;
    p_raw = {40'd0, raw_p};
    t_raw = {40'd0, raw_t};
    c1 = {48'd0, c.pressure_sensitivity};
    c2 = {48'd0, c.pressure_offset};
    c3 = {48'd0, c.sensitivity_temp_coeff};
    c4 = {48'd0, c.offset_temp_coeff};
    c5 = {48'd0, c.reference_temperature};
    c6 = {48'd0, c.temperature_coeff};

    // first order
    dt   = t_raw - c5 * 256;
    sens = c1 * 32768 + (c3 * dt) / 256;
    off  = c2 * 65536 + (c4 * dt) / 128;
    temp = 2000 + (dt * c6) / 8388608;

    // second order; the band is chosen on the first-order temperature
    x = temp - 2000;
    if (temp < 2000) begin
      t2    = (3 * (dt * dt)) / 64'sd8589934592;
      off2  = (3 * (x * x)) / 2;
      sens2 = (5 * (x * x)) / 8;
      band  = BAND_LOW;
      if (temp < -1500) begin
        y     = temp + 1500;
        off2  = off2 + 7 * (y * y);
        sens2 = sens2 + 4 * (y * y);
        band  = BAND_VERY_LOW;
      end
    end else begin
      t2    = (2 * (dt * dt)) / 64'sd137438953472;
      off2  = (x * x) / 16;
      sens2 = 0;
      band  = BAND_HIGH;
    end

    temp = temp - t2;
    pres = (((p_raw * (sens - sens2)) / 2097152 - (off - off2)) / 8192) / 10;
    r.temperature = temp[18:0];
    r.pressure    = pres[31:0];
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Input driver. The prediction is made at the edge that accepts a transaction.
  // The calibration changes only while nothing is in flight, so the shadow
  // copy is the one that the block uses.
  always @(posedge clk) begin
    reading_t    predicted;
    band_e       band;
    conversion_t item;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        compensate(in_raw_pressure, in_raw_temperature, cal_shadow, predicted, band);
        expected_readings.push_back(predicted);
        band_hits[band]++;
        conversions_taken++;
      end
      // hold the transaction while busy, otherwise move on
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_conversions.size() > 0) begin
          item = pending_conversions.pop_front();
          start              <= 1'b1;
          in_raw_pressure    <= item.raw_pressure;
          in_raw_temperature <= item.raw_temperature;
          // switch now and then between back-to-back bursts and random gaps
          if ($urandom_range(0, 31) == 0)
            back_to_back = !back_to_back;
          gap_left = back_to_back ? 0 : $urandom_range(0, 7);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor. A strobe lasts one cycle, so each result is checked at the edge that ends it.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid) begin
      if (expected_readings.size() == 0) begin
        report($sformatf("result with nothing outstanding: temperature %0d pressure %0d",
                         out_temperature, out_pressure));
      end else begin
        want = expected_readings.pop_front();
        results_checked++;
        if (out_temperature !== want.temperature)
          report($sformatf("temperature %0d, expected %0d", out_temperature, want.temperature));
        if (out_pressure !== want.pressure)
          report($sformatf("pressure %0d, expected %0d", out_pressure, want.pressure));
      end
    end
  end

  // Watchdog. It ends the run after too many cycles in which no transaction,
  // no result and no register write is accepted.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: %0d idle cycles, %0d results outstanding",
                 idle_cycles, expected_readings.size());
        $display("[pressure_temperature_compensation] ERROR");
        $finish;
      end
    end
  end

  // APB write: a setup cycle, then an access cycle that ends at the edge where pready is high.
  // An idle cycle follows, so that back-to-back calls never drive psel twice in one step.
  task automatic write_cal(input logic [ptc_pkg::REG_IDX_W-1:0] idx, input logic [15:0] value);
    logic [15:0] upper;
    upper = 16'($urandom_range(0, 16'hFFFF));   // the block ignores these bits
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {upper, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      ptc_pkg::REG_PRESSURE_SENSITIVITY:   cal_shadow.pressure_sensitivity   = value;
      ptc_pkg::REG_PRESSURE_OFFSET:        cal_shadow.pressure_offset        = value;
      ptc_pkg::REG_SENSITIVITY_TEMP_COEFF: cal_shadow.sensitivity_temp_coeff = value;
      ptc_pkg::REG_OFFSET_TEMP_COEFF:      cal_shadow.offset_temp_coeff      = value;
      ptc_pkg::REG_REFERENCE_TEMPERATURE:  cal_shadow.reference_temperature  = value;
      ptc_pkg::REG_TEMPERATURE_COEFF:      cal_shadow.temperature_coeff      = value;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_calibration(input logic [15:0] c1, input logic [15:0] c2,
                                  input logic [15:0] c3, input logic [15:0] c4,
                                  input logic [15:0] c5, input logic [15:0] c6);
    write_cal(ptc_pkg::REG_PRESSURE_SENSITIVITY,   c1);
    write_cal(ptc_pkg::REG_PRESSURE_OFFSET,        c2);
    write_cal(ptc_pkg::REG_SENSITIVITY_TEMP_COEFF, c3);
    write_cal(ptc_pkg::REG_OFFSET_TEMP_COEFF,      c4);
    write_cal(ptc_pkg::REG_REFERENCE_TEMPERATURE,  c5);
    write_cal(ptc_pkg::REG_TEMPERATURE_COEFF,      c6);
    cal_sets++;
  endtask

  function automatic void push_conversion(input logic [23:0] rp, input logic [23:0] rt);
    pending_conversions.push_back({rp, rt});
  endfunction

  // Random conversion pairs. The extremes come up often. About half of the
  // temperatures lie near the reference point, so all three bands are hit.
  task automatic queue_random(input int count);
    logic [23:0] rp, rt;
    longint      center, v;
    repeat (count) begin
      case ($urandom_range(0, 7))
        0:       rp = '0;
        1:       rp = '1;
        default: rp = 24'($urandom_range(0, 24'hFFFFFF));
      endcase
      case ($urandom_range(0, 9))
        0:       rt = '0;
        1:       rt = '1;
        2, 3, 4: rt = 24'($urandom_range(0, 24'hFFFFFF));
        default: begin
          center = {48'd0, cal_shadow.reference_temperature} * 256;
          v = center + longint'($urandom_range(0, 1 << 23)) - (1 << 22);
          if (v < 0)
            v = 0;
          if (v > 24'hFFFFFF)
            v = 24'hFFFFFF;
          rt = v[23:0];
        end
      endcase
      push_conversion(rp, rt);
    end
  endtask

  // Wait until every transaction is in and every result is back. Then wait out
  // the pipeline, so that a stray extra result is caught before anything changes.
  task automatic drain();
    while (pending_conversions.size() != 0 || start || expected_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [23:0] mid;
    logic [23:0] vlow;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset calibration (all zero): pressure comes out zero, temperature is 20.00 C less the second-order correction.
    queue_random(CONVERSIONS_PER_SET);
    drain();

    // Boundary calibration. With the reference at mid-scale and coeff 2^15,
    // every 256 raw counts are one hundredth of a degree. This puts the band
    // edges on exact raw codes.
    load_calibration(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'h8000, 16'h8000);
    mid  = {cal_shadow.reference_temperature, 8'h00};
    vlow = 24'(ptc_pkg::TEMP_VLOW_OFS * 256);
    push_conversion(24'h000000, 24'h000000);
    push_conversion(24'hFFFFFF, 24'hFFFFFF);
    push_conversion(24'h000000, 24'hFFFFFF);
    push_conversion(24'hFFFFFF, 24'h000000);
    push_conversion(24'hAAAAAA, mid);                     // exactly 20.00 C: high band
    push_conversion(24'h555555, mid - 24'd1);             // truncates back to 20.00 C
    push_conversion(24'hFFFFFF, mid - 24'd256);           // 19.99 C: low band
    push_conversion(24'h800000, mid + 24'd1);
    push_conversion(24'h123456, mid + 24'd256);
    push_conversion(24'hFFFFFF, mid - vlow);              // exactly -15.00 C: not very-low
    push_conversion(24'h400000, mid - vlow - 24'd1);      // truncates to -15.00 C
    push_conversion(24'hFFFFFF, mid - vlow - 24'd256);    // -15.01 C: very-low band
    push_conversion(24'h000001, mid - vlow - 24'd256);
    push_conversion(24'h7FFFFF, 24'h000001);
    push_conversion(24'hFFFFFE, 24'hFFFFFE);
    queue_random(CONVERSIONS_PER_SET - 15);
    drain();

    // Writes to unmapped indexes must not touch the calibration.
    write_cal(REG_UNMAPPED_LO, 16'hFFFF);
    write_cal(REG_UNMAPPED_HI, 16'h5A5A);
    queue_random(20);
    drain();

    // typical factory calibration
    load_calibration(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
    queue_random(CONVERSIONS_PER_SET);
    drain();

    // all words at full scale: deepest cold corner, largest corrections
    load_calibration('1, '1, '1, '1, '1, '1);
    queue_random(CONVERSIONS_PER_SET);
    drain();

    // alternating extremes, both phases
    load_calibration('1, '0, '1, '0, '1, '0);
    queue_random(CONVERSIONS_PER_SET);
    drain();
    load_calibration('0, '1, '0, '1, '0, '1);
    queue_random(CONVERSIONS_PER_SET);
    drain();

    repeat (4) begin
      load_calibration(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                       16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                       16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
      queue_random(CONVERSIONS_PER_SET);
      drain();
    end

    $display("%0d transactions in, %0d results checked, %0d calibration sets",
             conversions_taken, results_checked, cal_sets);
    $display("bands: %0d at/above 20 C, %0d below 20 C, %0d below -15 C; %0d mismatches",
             band_hits[BAND_HIGH], band_hits[BAND_LOW], band_hits[BAND_VERY_LOW], mismatches);
    if (mismatches == 0)
      $display("[pressure_temperature_compensation] OK");
    else
      $display("[pressure_temperature_compensation] ERROR");
    $finish;
  end

endmodule
